@@ hw/rtl/bekeg_pkg.sv @@
package bekeg_pkg;

   localparam int GAME_CFG_BITS = 48;
   localparam int MENU_CFG_BITS = 32;
   localparam int CSR_DATA_BITS = 48;
   localparam int CSR_ADDR_BITS = 1;

   localparam logic [CSR_ADDR_BITS-1:0] REG_GAME_CODES = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_MENU_CODES = 1'd1;

   typedef struct packed {
      logic found;
      logic is_press;
      logic last;
   } pick_type;

endpackage

@@ hw/rtl/button_edge_key_event_generator.sv @@
// Turns button bank samples into serial key press and release events.
// The req channel takes one word per tick: tdata holds the game button
// bits and then the menu button bits, and tuser holds the menu mode flag.
// The rsp channel gives one word per event: tdata holds the key code and
// the key echo, tuser is high for a press, and tlast marks the final
// event of a tick. A tick without edges gives no word at all.
// Key codes are written through the csr port; the user must write them
// only while no tick is in work, and the block itself does not enforce it.
// One lane per button finds its edge when the word is taken, and the edges
// go into the pend registers; a merge stage then hands out one event per
// cycle while the receiver takes them, in index order, releases of the bank
// just left first, each through the rsp output register. A tick gives at
// most GAME_BUTTONS + MENU_BUTTONS events.
// req_tready is low while events of a tick are still to be handed out.
// The rsp output register lets the next tick be taken while the last
// event waits; a stalled receiver holds the current word and pauses
// the merge stage. Reset clears the held buttons, the mode, the key
// codes and any pending events.
module button_edge_key_event_generator
   import bekeg_pkg::*;
#(
   parameter int GAME_BUTTONS = 6,
   parameter int MENU_BUTTONS = 4,
   parameter int KEY_BITS     = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // game_buttons_down, menu_buttons_down
   input  logic [((GAME_BUTTONS+MENU_BUTTONS+7)/8)*8-1:0] req_tdata,
   // menu_mode
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // key_code, key_echo
   output logic [((2*KEY_BITS+7)/8)*8-1:0] rsp_tdata,
   // is_press
   output logic                      rsp_tuser,
   output logic                      rsp_tlast,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int RSP_BITS  = ((2*KEY_BITS+7)/8)*8;
   localparam int GAME_CODE = GAME_BUTTONS*KEY_BITS;
   localparam int MENU_CODE = MENU_BUTTONS*KEY_BITS;
   localparam int GAME_EXT  = (GAME_CODE > GAME_CFG_BITS) ? GAME_CODE : GAME_CFG_BITS;
   localparam int MENU_EXT  = (MENU_CODE > MENU_CFG_BITS) ? MENU_CODE : MENU_CFG_BITS;

   logic [GAME_CFG_BITS-1:0] game_codes_ff, game_codes_in;
   logic [MENU_CFG_BITS-1:0] menu_codes_ff, menu_codes_in;
   logic [GAME_BUTTONS-1:0]  game_held_ff, game_held_in;
   logic [MENU_BUTTONS-1:0]  menu_held_ff, menu_held_in;
   logic                     mode_ff, mode_in;
   logic [GAME_BUTTONS-1:0]  pend_game_ff, pend_game_in;
   logic [GAME_BUTTONS-1:0]  press_game_ff, press_game_in;
   logic [MENU_BUTTONS-1:0]  pend_menu_ff, pend_menu_in;
   logic [MENU_BUTTONS-1:0]  press_menu_ff, press_menu_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]      rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff, rsp_user_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [GAME_EXT-1:0]      game_ext;
   logic [MENU_EXT-1:0]      menu_ext;
   logic                     req_take;
   logic                     mode_change;
   logic                     out_free;
   logic [GAME_BUTTONS-1:0]  lane_pend_game, lane_press_game, lane_held_game;
   logic [MENU_BUTTONS-1:0]  lane_pend_menu, lane_press_menu, lane_held_menu;
   logic [GAME_BUTTONS-1:0][KEY_BITS-1:0] codes_game;
   logic [MENU_BUTTONS-1:0][KEY_BITS-1:0] codes_menu;
   pick_type                 pick;
   logic [KEY_BITS-1:0]      pick_code;
   logic [GAME_BUTTONS-1:0]  game_clear;
   logic [MENU_BUTTONS-1:0]  menu_clear;

   assign game_ext = GAME_EXT'(game_codes_ff);
   assign menu_ext = MENU_EXT'(menu_codes_ff);

   assign req_tready  = (pend_game_ff == '0) && (pend_menu_ff == '0);
   assign req_take    = req_tvalid && req_tready;
   assign mode_change = req_tuser != mode_ff;
   assign out_free    = !rsp_valid_ff || rsp_tready;

   bekeg_lanes #(
      .BUTTONS  (GAME_BUTTONS),
      .KEY_BITS (KEY_BITS)
   ) u_game_lanes (
      .now          (req_tdata[GAME_BUTTONS-1:0]),
      .held         (game_held_ff),
      .codes_packed (game_ext[GAME_CODE-1:0]),
      .active       (!req_tuser),
      .release_all  (req_tuser && mode_change),
      .pend         (lane_pend_game),
      .press        (lane_press_game),
      .held_next    (lane_held_game),
      .codes        (codes_game)
   );

   bekeg_lanes #(
      .BUTTONS  (MENU_BUTTONS),
      .KEY_BITS (KEY_BITS)
   ) u_menu_lanes (
      .now          (req_tdata[GAME_BUTTONS +: MENU_BUTTONS]),
      .held         (menu_held_ff),
      .codes_packed (menu_ext[MENU_CODE-1:0]),
      .active       (req_tuser),
      .release_all  (!req_tuser && mode_change),
      .pend         (lane_pend_menu),
      .press        (lane_press_menu),
      .held_next    (lane_held_menu),
      .codes        (codes_menu)
   );

   bekeg_merge #(
      .GAME_BUTTONS (GAME_BUTTONS),
      .MENU_BUTTONS (MENU_BUTTONS),
      .KEY_BITS     (KEY_BITS)
   ) u_merge (
      .menu_mode  (mode_ff),
      .pend_game  (pend_game_ff),
      .press_game (press_game_ff),
      .codes_game (codes_game),
      .pend_menu  (pend_menu_ff),
      .press_menu (press_menu_ff),
      .codes_menu (codes_menu),
      .pick       (pick),
      .code       (pick_code),
      .game_clear (game_clear),
      .menu_clear (menu_clear)
   );

   always_comb begin
      game_codes_in = game_codes_ff;
      menu_codes_in = menu_codes_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_GAME_CODES: game_codes_in = csr_wdata[GAME_CFG_BITS-1:0];
            REG_MENU_CODES: menu_codes_in = csr_wdata[MENU_CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      game_held_in  = game_held_ff;
      menu_held_in  = menu_held_ff;
      mode_in       = mode_ff;
      pend_game_in  = pend_game_ff;
      press_game_in = press_game_ff;
      pend_menu_in  = pend_menu_ff;
      press_menu_in = press_menu_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;
      if (req_take) begin
         game_held_in  = lane_held_game;
         menu_held_in  = lane_held_menu;
         mode_in       = req_tuser;
         pend_game_in  = lane_pend_game;
         press_game_in = lane_press_game;
         pend_menu_in  = lane_pend_menu;
         press_menu_in = lane_press_menu;
      end else if (pick.found && out_free) begin
         pend_game_in = pend_game_ff & ~game_clear;
         pend_menu_in = pend_menu_ff & ~menu_clear;
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_BITS'({(pick.is_press ? pick_code : KEY_BITS'(0)), pick_code});
         rsp_user_in  = pick.is_press;
         rsp_last_in  = pick.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         game_codes_ff <= '0;
         menu_codes_ff <= '0;
         game_held_ff  <= '0;
         menu_held_ff  <= '0;
         mode_ff       <= 1'b0;
         pend_game_ff  <= '0;
         pend_menu_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         game_codes_ff <= game_codes_in;
         menu_codes_ff <= menu_codes_in;
         game_held_ff  <= game_held_in;
         menu_held_ff  <= menu_held_in;
         mode_ff       <= mode_in;
         pend_game_ff  <= pend_game_in;
         pend_menu_ff  <= pend_menu_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      press_game_ff <= press_game_in;
      press_menu_ff <= press_menu_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ hw/rtl/bekeg_lanes.sv @@
module bekeg_lanes
   import bekeg_pkg::*;
#(
   parameter int BUTTONS  = 6,
   parameter int KEY_BITS = 8
) (
   input  logic [BUTTONS-1:0]          now,
   input  logic [BUTTONS-1:0]          held,
   input  logic [BUTTONS*KEY_BITS-1:0] codes_packed,
   input  logic                        active,
   input  logic                        release_all,
   output logic [BUTTONS-1:0]          pend,
   output logic [BUTTONS-1:0]          press,
   output logic [BUTTONS-1:0]          held_next,
   output logic [BUTTONS-1:0][KEY_BITS-1:0] codes
);

   always_comb begin
      for (int i = 0; i < BUTTONS; i++) begin
         codes[i] = codes_packed[i*KEY_BITS +: KEY_BITS];
         if (active) begin
            pend[i]      = now[i] ^ held[i];
            press[i]     = now[i];
            held_next[i] = now[i];
         end else if (release_all) begin
            pend[i]      = held[i];
            press[i]     = 1'b0;
            held_next[i] = 1'b0;
         end else begin
            pend[i]      = 1'b0;
            press[i]     = 1'b0;
            held_next[i] = held[i];
         end
      end
   end

endmodule

@@ hw/rtl/bekeg_merge.sv @@
module bekeg_merge
   import bekeg_pkg::*;
#(
   parameter int GAME_BUTTONS = 6,
   parameter int MENU_BUTTONS = 4,
   parameter int KEY_BITS     = 8
) (
   input  logic                                   menu_mode,
   input  logic [GAME_BUTTONS-1:0]                pend_game,
   input  logic [GAME_BUTTONS-1:0]                press_game,
   input  logic [GAME_BUTTONS-1:0][KEY_BITS-1:0]  codes_game,
   input  logic [MENU_BUTTONS-1:0]                pend_menu,
   input  logic [MENU_BUTTONS-1:0]                press_menu,
   input  logic [MENU_BUTTONS-1:0][KEY_BITS-1:0]  codes_menu,
   output pick_type                               pick,
   output logic [KEY_BITS-1:0]                    code,
   output logic [GAME_BUTTONS-1:0]                game_clear,
   output logic [MENU_BUTTONS-1:0]                menu_clear
);

   logic                    game_any;
   logic                    menu_any;
   logic                    sel_menu;
   logic [GAME_BUTTONS-1:0] game_low;
   logic [MENU_BUTTONS-1:0] menu_low;

   assign game_any = |pend_game;
   assign menu_any = |pend_menu;

   // Releases of the bank just left come before the edges of the active bank.
   assign sel_menu = menu_mode ? !game_any : menu_any;

   assign game_low = pend_game & (~pend_game + GAME_BUTTONS'(1));
   assign menu_low = pend_menu & (~pend_menu + MENU_BUTTONS'(1));

   assign game_clear = sel_menu ? '0 : game_low;
   assign menu_clear = sel_menu ? menu_low : '0;

   always_comb begin
      code = '0;
      pick.is_press = 1'b0;
      for (int i = 0; i < GAME_BUTTONS; i++) begin
         if (game_clear[i]) begin
            code          = code | codes_game[i];
            pick.is_press = pick.is_press | press_game[i];
         end
      end
      for (int i = 0; i < MENU_BUTTONS; i++) begin
         if (menu_clear[i]) begin
            code          = code | codes_menu[i];
            pick.is_press = pick.is_press | press_menu[i];
         end
      end
      pick.found = game_any | menu_any;
      pick.last  = ((pend_game & ~game_clear) == '0) && ((pend_menu & ~menu_clear) == '0);
   end

endmodule

@@ bench/key_event_checker.sv @@
module key_event_checker
   import bekeg_pkg::*;
#(
   parameter int GAME_BUTTONS = 6,
   parameter int MENU_BUTTONS = 4,
   parameter int KEY_BITS     = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [15:0]              req_tdata,
   input  logic                     req_tuser,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [15:0]              rsp_tdata,
   input  logic                     rsp_tuser,
   input  logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       errors,
   output int                       pending
);

   typedef struct packed {
      logic                is_press;
      logic [KEY_BITS-1:0] key_code;
      logic [KEY_BITS-1:0] key_echo;
      logic                last_event;
   } key_event_type;

   key_event_type            events_due[$];
   logic [GAME_CFG_BITS-1:0] game_codes;
   logic [MENU_CFG_BITS-1:0] menu_codes;
   logic [GAME_BUTTONS-1:0]  game_held;
   logic [MENU_BUTTONS-1:0]  menu_held;
   logic                     was_menu;
   key_event_type            seen;
   key_event_type            due;

   task automatic push_event(input logic press, input logic [KEY_BITS-1:0] code);
      events_due.push_back('{press, code, press ? code : '0, 1'b0});
   endtask

   task automatic predict_tick(input logic [GAME_BUTTONS-1:0] game_now,
                               input logic [MENU_BUTTONS-1:0] menu_now,
                               input logic mode);
      int first;
      first = events_due.size();
      if (mode != was_menu) begin
         if (mode) begin
            for (int i = 0; i < GAME_BUTTONS; i++)
               if (game_held[i]) push_event(1'b0, game_codes[i*KEY_BITS +: KEY_BITS]);
            game_held = '0;
         end else begin
            for (int i = 0; i < MENU_BUTTONS; i++)
               if (menu_held[i]) push_event(1'b0, menu_codes[i*KEY_BITS +: KEY_BITS]);
            menu_held = '0;
         end
      end
      if (mode) begin
         for (int i = 0; i < MENU_BUTTONS; i++)
            if (menu_now[i] != menu_held[i])
               push_event(menu_now[i], menu_codes[i*KEY_BITS +: KEY_BITS]);
         menu_held = menu_now;
      end else begin
         for (int i = 0; i < GAME_BUTTONS; i++)
            if (game_now[i] != game_held[i])
               push_event(game_now[i], game_codes[i*KEY_BITS +: KEY_BITS]);
         game_held = game_now;
      end
      was_menu = mode;
      if (events_due.size() > first)
         events_due[events_due.size()-1].last_event = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         events_due.delete();
         game_codes = '0;
         menu_codes = '0;
         game_held  = '0;
         menu_held  = '0;
         was_menu   = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = '{rsp_tuser, rsp_tdata[KEY_BITS-1:0], rsp_tdata[2*KEY_BITS-1:KEY_BITS],
                     rsp_tlast};
            if (events_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual press=%0d code=%02h",
                        $time, seen.is_press, seen.key_code,
                        " echo=%02h last=%0d", seen.key_echo, seen.last_event);
               errors <= errors + 1;
            end else begin
               due = events_due.pop_front();
               if (seen != due) begin
                  $display("%0t: expected press=%0d code=%02h echo=%02h last=%0d,",
                           $time, due.is_press, due.key_code, due.key_echo, due.last_event,
                           " actual press=%0d code=%02h echo=%02h last=%0d",
                           seen.is_press, seen.key_code, seen.key_echo, seen.last_event);
                  errors <= errors + 1;
               end
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_GAME_CODES: game_codes = csr_wdata[GAME_CFG_BITS-1:0];
               REG_MENU_CODES: menu_codes = csr_wdata[MENU_CFG_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_tick(req_tdata[GAME_BUTTONS-1:0],
                         req_tdata[GAME_BUTTONS +: MENU_BUTTONS], req_tuser);
      end
      pending <= events_due.size();
   end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
   import bekeg_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 16;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [15:0]              req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [15:0]              rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   int   errors;
   int   pending;
   int   cycles    = 0;
   logic calm      = 1'b0;
   logic hold_go   = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;

   button_edge_key_event_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   key_event_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The receiver stalls at random, and once holds off for a long stretch
   // so that the block backs up into its input.
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 200;
      end
      rsp_tready <= !reset && hold_left == 0 && (calm || $urandom_range(99) >= 7);
      if (hold_left > 0) hold_left--;
   end

   task automatic write_regs(input logic [47:0] game_word, input logic [47:0] menu_word);
      csr_we    <= 1'b1;
      csr_addr  <= REG_GAME_CODES;
      csr_wdata <= game_word;
      @(posedge clock);
      csr_addr  <= REG_MENU_CODES;
      csr_wdata <= menu_word;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_tick(input logic [5:0] game, input logic [3:0] menu, input logic mode);
      while (!calm && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, menu, game};
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      logic [5:0]  game_sw;
      logic [3:0]  menu_sw;
      logic [5:0]  game_out;
      logic [3:0]  menu_out;
      logic        mode;
      logic [47:0] game_word;
      logic [47:0] menu_word;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First tick in menu mode, with the key codes still at reset.
      send_tick(6'h3F, 4'hF, 1'b1);
      drain();
      // Upper bits of the menu word lie beyond that register.
      write_regs(48'hA1B2_C3D4_E5F6, 48'hDEAD_1122_3344);
      send_tick(6'h00, 4'h0, 1'b1);
      send_tick(6'h3F, 4'hF, 1'b0);
      send_tick(6'h00, 4'hF, 1'b1);
      send_tick(6'h3F, 4'h0, 1'b0);
      send_tick(6'h3F, 4'h5, 1'b0);
      send_tick(6'h00, 4'hA, 1'b0);
      send_tick(6'h2A, 4'h3, 1'b0);
      send_tick(6'h15, 4'hC, 1'b0);
      send_tick(6'h3F, 4'h5, 1'b1);
      send_tick(6'h00, 4'hA, 1'b1);
      send_tick(6'h2A, 4'hA, 1'b1);
      send_tick(6'h15, 4'h0, 1'b1);
      send_tick(6'h01, 4'h8, 1'b0);
      send_tick(6'h20, 4'h1, 1'b0);
      send_tick(6'h20, 4'h1, 1'b1);
      send_tick(6'h3F, 4'hE, 1'b0);
      send_tick(6'h3F, 4'hE, 1'b0);
      drain();

      game_sw = '0;
      menu_sw = '0;
      mode    = 1'b0;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin
               game_word = '1;
               menu_word = '1;
            end
            2: begin
               game_word = '0;
               menu_word = '0;
            end
            default: begin
               game_word = {16'($urandom), 32'($urandom)};
               menu_word = {16'($urandom), 32'($urandom)};
            end
         endcase
         write_regs(game_word, menu_word);
         calm <= (phase == 2);
         for (int n = 0; n < 90; n++) begin
            if (phase == 1 && n == 20) hold_go <= 1'b1;
            if (phase == 3 && n == 40) drain();
            if ($urandom_range(99) < 12) mode = ~mode;
            if ($urandom_range(99) < 25) begin
               game_sw = 6'($urandom);
               menu_sw = 4'($urandom);
            end else if (mode) begin
               menu_sw[$urandom_range(3)] ^= 1'b1;
               if ($urandom_range(2) == 0) menu_sw[$urandom_range(3)] ^= 1'b1;
            end else begin
               game_sw[$urandom_range(5)] ^= 1'b1;
               if ($urandom_range(2) == 0) game_sw[$urandom_range(5)] ^= 1'b1;
            end
            game_out = game_sw;
            menu_out = menu_sw;
            if ($urandom_range(3) == 0) begin
               if (mode) game_out = 6'($urandom);
               else menu_out = 4'($urandom);
            end
            send_tick(game_out, menu_out, mode);
         end
         drain();
      end

      if (errors == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
